>>> hdl/cmyp_pkg.sv
// Shared types, constants and the month-letter decode for the contract
// month-year parser. No dependencies.
`default_nettype none

package cmyp_pkg;

  localparam int unsigned MAX_TOKEN_LEN = 255;
  localparam int unsigned COUNT_CAP_INT = (MAX_TOKEN_LEN < 255) ? MAX_TOKEN_LEN : 255;
  localparam logic [7:0]  COUNT_CAP     = 8'(COUNT_CAP_INT);

  localparam int unsigned CFG_W       = 13;
  localparam logic [CFG_W-1:0] LIMIT_RESET = 13'd1024;

  // Value width that covers every number that reaches the date split.
  localparam int unsigned VAL_W = 25;

  localparam logic [31:0] ABS_YEAR_END = 32'd4096;
  localparam logic [31:0] YM_END       = 32'd299913;
  localparam logic [31:0] YMD_END      = 32'd29991232;

  // x / 100 == (x * RECIP100) >> RECIP_SHIFT, exact for any 32-bit x.
  localparam logic [30:0] RECIP100    = 31'd1374389535;
  localparam int unsigned RECIP_SHIFT = 37;
  localparam int unsigned PROD1_W     = VAL_W + 31;
  localparam int unsigned Q1_W        = PROD1_W - RECIP_SHIFT;
  localparam int unsigned PROD2_W     = Q1_W + 31;
  localparam int unsigned Q2_W        = PROD2_W - RECIP_SHIFT;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_ERR_TAB = 2'd1;
  localparam logic [1:0] STATUS_ERR_NUL = 2'd2;

  localparam logic [7:0] CH_NUL  = 8'h00;
  localparam logic [7:0] CH_TAB  = 8'h09;
  localparam logic [7:0] CH_DASH = 8'h2d;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;

  typedef enum logic [1:0] {
    KIND_PASS,  // year and month taken as they are
    KIND_YM,    // YYYYMM: split by 100
    KIND_YMD    // YYYYMMDD: split by 100 twice
  } kind_e;

  typedef struct packed {
    logic             valid;
    kind_e            kind;
    logic [VAL_W-1:0] val;
    logic [6:0]       month;
    logic [1:0]       status;
    logic [7:0]       count;
  } cmyp_rec_t;

  function automatic logic [3:0] letter_value(input logic [7:0] c);
    logic [3:0] v;
    case (c | 8'h20)
      8'h66:   v = 4'd1;   // f
      8'h67:   v = 4'd2;   // g
      8'h68:   v = 4'd3;   // h
      8'h6a:   v = 4'd4;   // j
      8'h6b:   v = 4'd5;   // k
      8'h6d:   v = 4'd6;   // m
      8'h6e:   v = 4'd7;   // n
      8'h71:   v = 4'd8;   // q
      8'h75:   v = 4'd9;   // u
      8'h76:   v = 4'd10;  // v
      8'h78:   v = 4'd11;  // x
      8'h7a:   v = 4'd12;  // z
      default: v = 4'd0;
    endcase
    // the OR above also folds some non-letters; require a real letter
    if ((c < 8'h41) || ((c > 8'h5a) && (c < 8'h61)) || (c > 8'h7a)) begin
      v = 4'd0;
    end
    return v;
  endfunction

endpackage

`default_nettype wire

>>> hdl/cmyp_parse.sv
// Per-character token scanner: phase, accumulators and length counter.
// Hands one raw request per finished token to the split pipeline. Uses cmyp_pkg.
`default_nettype none

module cmyp_parse (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic [7:0]          ch_i,
  output logic                in_stall_o,
  input  logic [12:0]         limit_i,
  output cmyp_pkg::cmyp_rec_t rec_o,
  input  logic                rec_ready_i
);
  import cmyp_pkg::*;

  localparam logic [1:0] PH_START = 2'd0;
  localparam logic [1:0] PH_NUM   = 2'd1;
  localparam logic [1:0] PH_MONTH = 2'd2;
  localparam logic [1:0] PH_SKIP  = 2'd3;

  logic [1:0]  phase_q, phase_d;
  logic [3:0]  letter_q, letter_d;
  logic [31:0] acc_q, acc_d;
  logic [7:0]  sec_q, sec_d;
  logic        seen_q, seen_d;
  logic [7:0]  cnt_q, cnt_d;
  cmyp_rec_t   rec_q, rec_d;

  logic        accept, load, emit;
  logic        is_digit;
  logic [3:0]  dval, lm;
  logic [7:0]  cnt_inc;
  logic [31:0] acc_x10;
  logic [11:0] sec_x10;
  logic [7:0]  sec_sat;
  kind_e       e_kind;
  logic [6:0]  e_month;
  logic [1:0]  e_status;

  assign load       = !rec_q.valid || rec_ready_i;
  assign in_stall_o = !load;
  assign accept     = in_valid_i && load;
  assign rec_o      = rec_q;

  assign is_digit = (ch_i >= CH_ZERO) && (ch_i <= CH_NINE);
  assign dval     = 4'(ch_i - CH_ZERO);
  assign lm       = letter_value(ch_i);
  assign cnt_inc  = (cnt_q < COUNT_CAP) ? cnt_q + 8'd1 : cnt_q;
  assign acc_x10  = (acc_q << 3) + (acc_q << 1) + {28'b0, dval};
  assign sec_x10  = ({4'b0, sec_q} << 3) + ({4'b0, sec_q} << 1) + {8'b0, dval};
  assign sec_sat  = (sec_x10 > 12'd255) ? 8'hff : sec_x10[7:0];

  always_comb begin
    phase_d  = phase_q;
    letter_d = letter_q;
    acc_d    = acc_q;
    sec_d    = sec_q;
    seen_d   = seen_q;
    cnt_d    = cnt_q;
    emit     = 1'b0;
    e_kind   = KIND_PASS;
    e_month  = 7'd0;
    e_status = STATUS_OK;

    case (phase_q)
      PH_START, PH_NUM: begin
        if ((phase_q == PH_START) && (lm != 4'd0)) begin
          letter_d = lm;
          phase_d  = PH_NUM;
          cnt_d    = cnt_inc;
        end else if (is_digit) begin
          acc_d   = acc_x10;
          seen_d  = 1'b1;
          phase_d = PH_NUM;
          cnt_d   = cnt_inc;
        end else if (!seen_q) begin
          if (ch_i == CH_TAB) begin
            emit     = 1'b1;
            e_status = STATUS_ERR_TAB;
          end else if (ch_i == CH_NUL) begin
            emit     = 1'b1;
            e_status = STATUS_ERR_NUL;
          end else begin
            phase_d = PH_SKIP;
            cnt_d   = cnt_inc;
          end
        end else if (acc_q < 32'(limit_i)) begin
          emit    = 1'b1;
          e_month = {3'b0, letter_q};
        end else if (acc_q < ABS_YEAR_END) begin
          if ((letter_q == 4'd0) && (ch_i == CH_DASH)) begin
            phase_d = PH_MONTH;
            seen_d  = 1'b0;
            sec_d   = 8'd0;
            cnt_d   = cnt_inc;
          end else begin
            emit    = 1'b1;
            e_month = {3'b0, letter_q};
          end
        end else if (acc_q < YM_END) begin
          emit   = 1'b1;
          e_kind = KIND_YM;
        end else if (acc_q < YMD_END) begin
          emit   = 1'b1;
          e_kind = KIND_YMD;
        end else begin
          emit     = 1'b1;
          e_status = (ch_i == CH_NUL) ? STATUS_ERR_NUL : STATUS_ERR_TAB;
        end
      end
      PH_MONTH: begin
        if (is_digit) begin
          sec_d  = sec_sat;
          seen_d = 1'b1;
          cnt_d  = cnt_inc;
        end else begin
          emit    = 1'b1;
          e_month = (!seen_q || (sec_q > 8'd12)) ? 7'd0 : sec_q[6:0];
        end
      end
      default: begin
        if (ch_i == CH_TAB) begin
          emit     = 1'b1;
          e_status = STATUS_ERR_TAB;
        end else if (ch_i == CH_NUL) begin
          emit     = 1'b1;
          e_status = STATUS_ERR_NUL;
        end else begin
          phase_d = PH_SKIP;
          cnt_d   = cnt_inc;
        end
      end
    endcase

    // error requests carry a zero value so the split yields zero fields
    rec_d.valid  = accept && emit;
    rec_d.kind   = e_kind;
    rec_d.val    = (e_status == STATUS_OK) ? acc_q[VAL_W-1:0] : '0;
    rec_d.month  = e_month;
    rec_d.status = e_status;
    rec_d.count  = cnt_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_START;
      letter_q <= 4'd0;
      acc_q    <= 32'd0;
      sec_q    <= 8'd0;
      seen_q   <= 1'b0;
      cnt_q    <= 8'd0;
    end else if (accept) begin
      if (emit) begin
        phase_q  <= PH_START;
        letter_q <= 4'd0;
        acc_q    <= 32'd0;
        sec_q    <= 8'd0;
        seen_q   <= 1'b0;
        cnt_q    <= 8'd0;
      end else begin
        phase_q  <= phase_d;
        letter_q <= letter_d;
        acc_q    <= acc_d;
        sec_q    <= sec_d;
        seen_q   <= seen_d;
        cnt_q    <= cnt_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rec_q <= '0;
    end else if (load) begin
      rec_q <= rec_d;
    end
  end

endmodule

`default_nettype wire

>>> hdl/cmyp_split.sv
// Date split pipeline: two reciprocal multiplies by 1/100 and the output
// register with its stall handshake. Uses cmyp_pkg.
`default_nettype none

module cmyp_split (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cmyp_pkg::cmyp_rec_t rec_i,
  output logic                rec_ready_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [11:0]         year_o,
  output logic [6:0]          month_o,
  output logic [6:0]          day_o,
  output logic                month_only_form_o,
  output logic [1:0]          status_o,
  output logic [7:0]          consumed_length_o
);
  import cmyp_pkg::*;

  // stage 2: first multiply
  logic               s2_valid_q;
  kind_e              s2_kind_q;
  logic [VAL_W-1:0]   s2_val_q;
  logic [6:0]         s2_month_q;
  logic [1:0]         s2_status_q;
  logic [7:0]         s2_count_q;
  logic [PROD1_W-1:0] s2_prod_q;

  // stage 3: first remainder, second multiply
  logic               s3_valid_q;
  kind_e              s3_kind_q;
  logic [11:0]        s3_year_q, s3_year_d;
  logic [6:0]         s3_month_q, s3_month_d;
  logic [6:0]         s3_day_q;
  logic               s3_mo_q;
  logic [1:0]         s3_status_q;
  logic [7:0]         s3_count_q;
  logic [Q1_W-1:0]    s3_q1_q;
  logic [PROD2_W-1:0] s3_prod_q;

  logic [11:0]        year_q, year_d;
  logic [6:0]         month_q, month_d;
  logic [6:0]         day_q;
  logic               mo_q;
  logic [1:0]         status_q;
  logic [7:0]         count_q;
  logic               out_valid_q;

  logic               adv2, adv3, adv4;
  logic [Q1_W-1:0]    q1;
  logic [VAL_W-1:0]   rem1;
  logic [Q2_W-1:0]    q2;
  logic [Q1_W-1:0]    rem2;

  assign adv4        = !out_valid_q || !out_stall_i;
  assign adv3        = !s3_valid_q || adv4;
  assign adv2        = !s2_valid_q || adv3;
  assign rec_ready_o = adv2;

  assign q1   = s2_prod_q[PROD1_W-1:RECIP_SHIFT];
  assign rem1 = s2_val_q - VAL_W'(VAL_W'(q1) * VAL_W'(100));
  assign q2   = s3_prod_q[PROD2_W-1:RECIP_SHIFT];
  assign rem2 = s3_q1_q - Q1_W'(Q1_W'(q2) * Q1_W'(100));

  always_comb begin
    s3_year_d  = s2_val_q[11:0];
    s3_month_d = s2_month_q;
    if (s2_kind_q == KIND_YM) begin
      s3_year_d  = q1[11:0];
      s3_month_d = rem1[6:0];
    end
    year_d  = s3_year_q;
    month_d = s3_month_q;
    if (s3_kind_q == KIND_YMD) begin
      year_d  = q2[11:0];
      month_d = rem2[6:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (adv2) s2_valid_q  <= rec_i.valid;
      if (adv3) s3_valid_q  <= s2_valid_q;
      if (adv4) out_valid_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv2) begin
      s2_kind_q   <= rec_i.kind;
      s2_val_q    <= rec_i.val;
      s2_month_q  <= rec_i.month;
      s2_status_q <= rec_i.status;
      s2_count_q  <= rec_i.count;
      s2_prod_q   <= PROD1_W'(rec_i.val) * PROD1_W'(RECIP100);
    end
    if (adv3) begin
      s3_kind_q   <= s2_kind_q;
      s3_year_q   <= s3_year_d;
      s3_month_q  <= s3_month_d;
      s3_day_q    <= (s2_kind_q == KIND_YMD) ? rem1[6:0] : 7'd0;
      s3_mo_q     <= (s2_kind_q == KIND_YM);
      s3_status_q <= s2_status_q;
      s3_count_q  <= s2_count_q;
      s3_q1_q     <= q1;
      s3_prod_q   <= PROD2_W'(q1) * PROD2_W'(RECIP100);
    end
    if (adv4) begin
      year_q   <= year_d;
      month_q  <= month_d;
      day_q    <= s3_day_q;
      mo_q     <= s3_mo_q;
      status_q <= s3_status_q;
      count_q  <= s3_count_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign year_o            = year_q;
  assign month_o           = month_q;
  assign day_o             = day_q;
  assign month_only_form_o = mo_q;
  assign status_o          = status_q;
  assign consumed_length_o = count_q;

endmodule

`default_nettype wire

>>> hdl/contract_month_year_parser_unit.sv
// Contract month-year parser, one ASCII character accepted per clock while
// in_stall_o is low. Each character is decoded and folded into the token
// state in the cycle it is accepted (the multiply-by-ten accumulate sets
// that rate). The terminator's result passes the scanner's request register,
// split stages 2 and 3 and the output register, after two reciprocal
// multiplies that split YYYYMM and YYYYMMDD by 100. With these four result
// stages, input is stalled only once all hold results waiting on the output
// side. The relative-year limit goes through the cfg port, always ready.
// Top level: instantiates cmyp_parse and cmyp_split; uses cmyp_pkg.
`default_nettype none

module contract_month_year_parser_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  ch_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [11:0] year_o,
  output logic [6:0]  month_o,
  output logic [6:0]  day_o,
  output logic        month_only_form_o,
  output logic [1:0]  status_o,
  output logic [7:0]  consumed_length_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [cmyp_pkg::CFG_W-1:0] cfg_data_i
);
  import cmyp_pkg::*;

  logic [CFG_W-1:0] limit_q;
  cmyp_rec_t        rec;
  logic             rec_ready;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LIMIT_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      limit_q <= cfg_data_i;
    end
  end

  cmyp_parse u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .ch_i        (ch_i),
    .in_stall_o  (in_stall_o),
    .limit_i     (limit_q),
    .rec_o       (rec),
    .rec_ready_i (rec_ready)
  );

  cmyp_split u_split (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .rec_i             (rec),
    .rec_ready_o       (rec_ready),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .year_o            (year_o),
    .month_o           (month_o),
    .day_o             (day_o),
    .month_only_form_o (month_only_form_o),
    .status_o          (status_o),
    .consumed_length_o (consumed_length_o)
  );

endmodule

`default_nettype wire

>>> hdl/cmyp_checker.sv
// Port-level checks for the contract month-year parser, bound to the top.
// Depends only on the top-level ports.
`default_nettype none

module cmyp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [11:0] year_o,
  input logic [6:0]  month_o,
  input logic [6:0]  day_o,
  input logic        month_only_form_o,
  input logic [1:0]  status_o,
  input logic [7:0]  consumed_length_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(year_o) && $stable(month_o) &&
      $stable(day_o) && $stable(status_o) && $stable(consumed_length_o))
    else $error("stalled result changed");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o != 2'd3)
    else $error("undefined status code");

  a_error_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != 2'd0) |->
      (year_o == 12'd0) && (month_o == 7'd0) && (day_o == 7'd0) && !month_only_form_o)
    else $error("error result with nonzero date fields");

  a_month_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && month_only_form_o |->
      (day_o == 7'd0) && (status_o == 2'd0) && (month_o < 7'd100))
    else $error("bad YYYYMM result");

endmodule

bind contract_month_year_parser_unit cmyp_checker u_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .out_valid_o       (out_valid_o),
  .out_stall_i       (out_stall_i),
  .year_o            (year_o),
  .month_o           (month_o),
  .day_o             (day_o),
  .month_only_form_o (month_only_form_o),
  .status_o          (status_o),
  .consumed_length_o (consumed_length_o)
);

`default_nettype wire
